/* hdl/i2cmrb_pkg.sv */
package i2cmrb_pkg;

  // Register offsets in the access window
  localparam logic [13:0] OFF_OWN_ADDR = 14'h0000;
  localparam logic [13:0] OFF_CLK_DIV  = 14'h0004;
  localparam logic [13:0] OFF_CONTROL  = 14'h0008;
  localparam logic [13:0] OFF_STATUS   = 14'h000C;
  localparam logic [13:0] OFF_DATA     = 14'h0010;

  // Control register bits
  localparam logic [15:0] CR_MSTA = 16'h0020;
  localparam logic [15:0] CR_MTX  = 16'h0010;
  localparam logic [15:0] CR_RSTA = 16'h0004;

  // Status register bits
  localparam logic [15:0] SR_ICF  = 16'h0080;
  localparam logic [15:0] SR_IBB  = 16'h0020;
  localparam logic [15:0] SR_IAL  = 16'h0010;
  localparam logic [15:0] SR_IIF  = 16'h0002;
  localparam logic [15:0] SR_RXAK = 16'h0001;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [13:0] addr_offset;
    logic        halfword_access;
    logic [15:0] write_data;
    logic        slave_present;
    logic [7:0]  slave_rx_byte;
    logic        slave_extra_completion;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        access_error;
    logic        unknown_slave;
    logic        slave_start;
    logic        slave_start_read;
    logic [6:0]  slave_address;
    logic        slave_write_strobe;
    logic [7:0]  slave_write_byte;
    logic        slave_read_strobe;
    logic        completion_query;
  } rsp_t;

endpackage

/* hdl/i2c_master_register_block_core.sv */
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | req (i2cmrb_pkg::req_t), one bus access
// rsp     | out       | rsp_valid, rsp_stall | rsp (i2cmrb_pkg::rsp_t), its result
//
// Each accepted req beat is decoded and applied to the register state in the
// cycle it is accepted; its result is registered into rsp, or into the skid
// register while rsp waits. Sustained rate is one beat per cycle while rsp_stall is low.
// A two-entry output stage (result register plus skid register) lets a new
// req beat in while a result waits; req_stall rises only when both are full.
// Reset (rst, synchronous) zeroes the state registers except expect_address, which
// it sets, and empties the output stage.
module i2c_master_register_block_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  i2cmrb_pkg::req_t   req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output i2cmrb_pkg::rsp_t   rsp
);

  // Architectural state
  logic [15:0] own_address_reg,   own_address_reg_next;
  logic [15:0] clock_divider_reg, clock_divider_reg_next;
  logic [15:0] control_reg,       control_reg_next;
  logic [15:0] status_reg,        status_reg_next;
  logic [15:0] data_reg,          data_reg_next;
  logic        slave_selected,    slave_selected_next;
  logic [6:0]  selected_address,  selected_address_next;
  logic [7:0]  receive_shift,     receive_shift_next;
  logic        expect_address,    expect_address_next;
  logic        reading_phase,     reading_phase_next;
  logic        dummy_read_pending,    dummy_read_pending_next;
  logic        stop_after_final_read, stop_after_final_read_next;
  logic        transmit_done_pending, transmit_done_pending_next;

  // Output stage
  logic             skid_valid;
  i2cmrb_pkg::rsp_t skid;
  i2cmrb_pkg::rsp_t result;

  logic accept;
  logic take;

  assign req_stall = skid_valid;
  assign accept    = req_valid & ~req_stall;
  assign take      = rsp_valid & ~rsp_stall;

  // Decode the access and compute the next state and the result beat.
  always_comb begin
    logic [13:0] off;
    logic        lane;
    logic        err;
    logic [15:0] v;
    logic [15:0] val;
    logic [15:0] s;
    logic        was_m;
    logic        is_m;
    logic        rep;
    logic        had;
    logic [7:0]  b;
    logic        unk;

    own_address_reg_next       = own_address_reg;
    clock_divider_reg_next     = clock_divider_reg;
    control_reg_next           = control_reg;
    status_reg_next            = status_reg;
    data_reg_next              = data_reg;
    slave_selected_next        = slave_selected;
    selected_address_next      = selected_address;
    receive_shift_next         = receive_shift;
    expect_address_next        = expect_address;
    reading_phase_next         = reading_phase;
    dummy_read_pending_next    = dummy_read_pending;
    stop_after_final_read_next = stop_after_final_read;
    transmit_done_pending_next = transmit_done_pending;
    result = '0;
    v      = '0;
    s      = status_reg;
    was_m  = 1'b0;
    is_m   = 1'b0;
    rep    = 1'b0;
    had    = 1'b0;
    b      = '0;
    unk    = 1'b0;

    // Byte accesses pick a lane with bit 0; halfword accesses must be even.
    lane = ~req.halfword_access & req.addr_offset[0];
    off  = req.halfword_access ? req.addr_offset : {req.addr_offset[13:1], 1'b0};
    err  = req.halfword_access & req.addr_offset[0];
    if (off != i2cmrb_pkg::OFF_OWN_ADDR && off != i2cmrb_pkg::OFF_CLK_DIV &&
        off != i2cmrb_pkg::OFF_CONTROL && off != i2cmrb_pkg::OFF_STATUS &&
        off != i2cmrb_pkg::OFF_DATA) begin
      err = 1'b1;
    end

    if (req.halfword_access) begin
      val = req.write_data;
    end else if (lane) begin
      val = {req.write_data[7:0], 8'h00};
    end else begin
      val = {8'h00, req.write_data[7:0]};
    end

    if (err) begin
      // Unsupported offset: flag it, touch nothing.
      result.access_error = 1'b1;
    end else if (req.cmd == i2cmrb_pkg::CMD_READ) begin
      unique case (off)
        i2cmrb_pkg::OFF_OWN_ADDR: begin
          v = own_address_reg;
        end
        i2cmrb_pkg::OFF_CLK_DIV: begin
          v = clock_divider_reg;
        end
        i2cmrb_pkg::OFF_CONTROL: begin
          v = control_reg;
        end
        i2cmrb_pkg::OFF_STATUS: begin
          // Complete a transmitted byte that is still pending.
          if ((control_reg & i2cmrb_pkg::CR_MSTA) != '0 &&
              (s & i2cmrb_pkg::SR_IIF) == '0 && transmit_done_pending) begin
            s = s | i2cmrb_pkg::SR_ICF | i2cmrb_pkg::SR_IIF;
            transmit_done_pending_next = 1'b0;
          end
          // Master receive completes a byte on its own.
          if (slave_selected && reading_phase && !dummy_read_pending &&
              (control_reg & (i2cmrb_pkg::CR_MSTA | i2cmrb_pkg::CR_MTX)) ==
                i2cmrb_pkg::CR_MSTA &&
              (s & i2cmrb_pkg::SR_IIF) == '0) begin
            s = s | i2cmrb_pkg::SR_ICF | i2cmrb_pkg::SR_IIF;
          end
          s = (s & (i2cmrb_pkg::SR_ICF | i2cmrb_pkg::SR_IIF | i2cmrb_pkg::SR_IAL |
                    i2cmrb_pkg::SR_RXAK)) |
              (((control_reg & i2cmrb_pkg::CR_MSTA) != '0) ? i2cmrb_pkg::SR_IBB : '0);
          status_reg_next = s;
          v = s;
        end
        default: begin
          // Data read: the shift register lags one byte behind the bus.
          s = s | i2cmrb_pkg::SR_ICF;
          v = data_reg;
          if (slave_selected && reading_phase &&
              (control_reg & i2cmrb_pkg::CR_MTX) == '0) begin
            receive_shift_next      = req.slave_rx_byte;
            result.slave_read_strobe = 1'b1;
            dummy_read_pending_next = 1'b0;
            data_reg_next           = {8'h00, receive_shift};
            v                       = {8'h00, receive_shift};
            s = s | i2cmrb_pkg::SR_IIF;
            if (stop_after_final_read) begin
              slave_selected_next        = 1'b0;
              reading_phase_next         = 1'b0;
              stop_after_final_read_next = 1'b0;
            end
          end
          status_reg_next = s;
        end
      endcase
      if (req.halfword_access) begin
        result.read_data = v;
      end else if (lane) begin
        result.read_data = {8'h00, v[15:8]};
      end else begin
        result.read_data = {8'h00, v[7:0]};
      end
    end else begin
      unique case (off)
        i2cmrb_pkg::OFF_OWN_ADDR: begin
          own_address_reg_next = val;
        end
        i2cmrb_pkg::OFF_CLK_DIV: begin
          clock_divider_reg_next = val;
        end
        i2cmrb_pkg::OFF_CONTROL: begin
          was_m = (control_reg & i2cmrb_pkg::CR_MSTA) != '0;
          is_m  = (val & i2cmrb_pkg::CR_MSTA) != '0;
          rep   = was_m && is_m && (val & i2cmrb_pkg::CR_RSTA) != '0 &&
                  (control_reg & i2cmrb_pkg::CR_RSTA) == '0;
          control_reg_next = val;
          if (!was_m && is_m) begin
            // START
            status_reg_next     = status_reg | i2cmrb_pkg::SR_IBB;
            expect_address_next = 1'b1;
          end else if (rep) begin
            expect_address_next = 1'b1;
          end else if (was_m && !is_m) begin
            // STOP: hold the slave until its final read if receiving.
            status_reg_next = (status_reg & ~i2cmrb_pkg::SR_IBB) |
                              i2cmrb_pkg::SR_ICF | i2cmrb_pkg::SR_IIF;
            expect_address_next        = 1'b1;
            dummy_read_pending_next    = 1'b0;
            transmit_done_pending_next = 1'b0;
            if (slave_selected && reading_phase) begin
              stop_after_final_read_next = 1'b1;
            end else begin
              slave_selected_next        = 1'b0;
              reading_phase_next         = 1'b0;
              stop_after_final_read_next = 1'b0;
            end
          end else if (is_m && slave_selected && reading_phase &&
                       (control_reg & i2cmrb_pkg::CR_MTX) != '0 &&
                       (val & i2cmrb_pkg::CR_MTX) == '0) begin
            // Switch to receive: the next data read is a dummy read.
            receive_shift_next      = '0;
            dummy_read_pending_next = 1'b1;
          end
        end
        i2cmrb_pkg::OFF_STATUS: begin
          had = (status_reg & i2cmrb_pkg::SR_IIF) != '0;
          s   = status_reg & (val | ~(i2cmrb_pkg::SR_IIF | i2cmrb_pkg::SR_IAL));
          status_reg_next = s;
          if (had && (s & i2cmrb_pkg::SR_IIF) == '0 && slave_selected) begin
            result.completion_query = 1'b1;
            if (req.slave_extra_completion) begin
              transmit_done_pending_next = 1'b1;
            end
          end
        end
        default: begin
          b = val[7:0];
          data_reg_next = val;
          if ((control_reg & i2cmrb_pkg::CR_MTX) != '0) begin
            if (expect_address) begin
              // Address byte: select the slave and record the direction.
              selected_address_next = b[7:1];
              reading_phase_next    = b[0];
              if (!req.slave_present) begin
                slave_selected_next = 1'b0;
                s   = s | i2cmrb_pkg::SR_RXAK;
                unk = 1'b1;
              end else begin
                slave_selected_next     = 1'b1;
                result.slave_start      = 1'b1;
                result.slave_start_read = b[0];
              end
              if (b[0]) begin
                dummy_read_pending_next = 1'b1;
                receive_shift_next      = '0;
              end
              expect_address_next = 1'b0;
            end else if (slave_selected && !reading_phase) begin
              result.slave_write_strobe = 1'b1;
              result.slave_write_byte   = b;
            end
          end
          s = s & ~i2cmrb_pkg::SR_ICF;
          transmit_done_pending_next = 1'b1;
          if (!unk) begin
            s = s & ~i2cmrb_pkg::SR_RXAK;
          end
          status_reg_next = s;
        end
      endcase
    end

    result.unknown_slave = unk;
    if (!err && (slave_selected_next || result.slave_start || result.slave_write_strobe ||
                 result.slave_read_strobe || unk)) begin
      result.slave_address = selected_address_next;
    end
  end

  // Advance state on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address_reg       <= '0;
      clock_divider_reg     <= '0;
      control_reg           <= '0;
      status_reg            <= '0;
      data_reg              <= '0;
      slave_selected        <= 1'b0;
      selected_address      <= '0;
      receive_shift         <= '0;
      expect_address        <= 1'b1;
      reading_phase         <= 1'b0;
      dummy_read_pending    <= 1'b0;
      stop_after_final_read <= 1'b0;
      transmit_done_pending <= 1'b0;
    end else if (accept) begin
      own_address_reg       <= own_address_reg_next;
      clock_divider_reg     <= clock_divider_reg_next;
      control_reg           <= control_reg_next;
      status_reg            <= status_reg_next;
      data_reg              <= data_reg_next;
      slave_selected        <= slave_selected_next;
      selected_address      <= selected_address_next;
      receive_shift         <= receive_shift_next;
      expect_address        <= expect_address_next;
      reading_phase         <= reading_phase_next;
      dummy_read_pending    <= dummy_read_pending_next;
      stop_after_final_read <= stop_after_final_read_next;
      transmit_done_pending <= transmit_done_pending_next;
    end
  end

  // Output stage: the skid register drains into rsp first, keeping order.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !rsp_valid) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !rsp_valid) begin
      if (skid_valid) begin
        rsp <= skid;
      end else if (accept) begin
        rsp <= result;
      end
    end else if (accept) begin
      skid <= result;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import i2cmrb_pkg::*;

  // Generous ceiling: about 1650 beats, each at worst a long sender gap plus
  // a long receiver stall, taken many times over.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          RANDOM_BEATS = 1600;

  // Register model of the controller plus the queue of results it predicts.
  class i2c_reg_scoreboard;
    bit [15:0] own_addr, clk_div, ctrl, stat, data;
    bit        sel;
    bit [6:0]  sel_addr;
    bit [7:0]  rx_shift;
    bit        want_addr, rd_phase, dummy_rd, stop_final, tx_done;

    rsp_t      expected_results[$];
    int        checked, mismatches;
    int        n_starts, n_unknown, n_wstb, n_rstb, n_cq, n_err;

    function new();
      own_addr = '0; clk_div = '0; ctrl = '0; stat = '0; data = '0;
      sel = 0; sel_addr = '0; rx_shift = '0;
      want_addr = 1; rd_phase = 0; dummy_rd = 0; stop_final = 0; tx_done = 0;
    endfunction

    function void drop_slave();
      sel = 0;
      rd_phase = 0;
      stop_final = 0;
    endfunction

    function rsp_t predict_access(req_t a);
      rsp_t      r;
      bit [13:0] off;
      bit        lane, err, was_m, is_m, rep, had;
      bit [15:0] v, val;
      bit [7:0]  b, prev;
      r = '0;
      off = a.addr_offset;
      lane = 0;
      err = 0;
      v = '0;
      if (!a.halfword_access) begin
        lane = off[0];
        off[0] = 1'b0;
      end else if (off[0]) begin
        err = 1;
      end
      if (!(off inside {OFF_OWN_ADDR, OFF_CLK_DIV, OFF_CONTROL, OFF_STATUS, OFF_DATA}))
        err = 1;
      if (err) begin
        r.access_error = 1'b1;
        return r;
      end

      if (a.cmd == CMD_READ) begin
        case (off)
          OFF_OWN_ADDR: v = own_addr;
          OFF_CLK_DIV:  v = clk_div;
          OFF_CONTROL:  v = ctrl;
          OFF_STATUS: begin
            if ((ctrl & CR_MSTA) != 0 && (stat & SR_IIF) == 0 && tx_done) begin
              stat |= SR_ICF | SR_IIF;
              tx_done = 0;
            end
            if (sel && rd_phase && !dummy_rd && (ctrl & (CR_MSTA | CR_MTX)) == CR_MSTA &&
                (stat & SR_IIF) == 0)
              stat |= SR_ICF | SR_IIF;
            stat = (stat & (SR_ICF | SR_IIF | SR_IAL | SR_RXAK)) |
                   (((ctrl & CR_MSTA) != 0) ? SR_IBB : 16'h0000);
            v = stat;
          end
          default: begin
            stat |= SR_ICF;
            if (sel && rd_phase && (ctrl & CR_MTX) == 0) begin
              prev = rx_shift;
              rx_shift = a.slave_rx_byte;
              r.slave_read_strobe = 1'b1;
              dummy_rd = 0;
              data = {8'h00, prev};
              stat |= SR_IIF;
              if (stop_final) drop_slave();
            end
            v = data;
          end
        endcase
        r.read_data = a.halfword_access ? v : (lane ? {8'h00, v[15:8]} : {8'h00, v[7:0]});
      end else begin
        val = a.halfword_access ? a.write_data :
              (lane ? {a.write_data[7:0], 8'h00} : {8'h00, a.write_data[7:0]});
        case (off)
          OFF_OWN_ADDR: own_addr = val;
          OFF_CLK_DIV:  clk_div = val;
          OFF_CONTROL: begin
            was_m = (ctrl & CR_MSTA) != 0;
            is_m = (val & CR_MSTA) != 0;
            rep = was_m && is_m && (val & CR_RSTA) != 0 && (ctrl & CR_RSTA) == 0;
            if (!was_m && is_m) begin
              stat |= SR_IBB;
              want_addr = 1;
            end else if (rep) begin
              want_addr = 1;
            end else if (was_m && !is_m) begin
              stat = (stat & ~SR_IBB) | SR_ICF | SR_IIF;
              want_addr = 1;
              dummy_rd = 0;
              tx_done = 0;
              if (sel && rd_phase) stop_final = 1;
              else drop_slave();
            end else if (is_m && sel && rd_phase && (ctrl & CR_MTX) != 0 &&
                         (val & CR_MTX) == 0) begin
              rx_shift = '0;
              dummy_rd = 1;
            end
            ctrl = val;
          end
          OFF_STATUS: begin
            had = (stat & SR_IIF) != 0;
            stat &= val | ~(SR_IIF | SR_IAL);
            if (had && (stat & SR_IIF) == 0 && sel) begin
              r.completion_query = 1'b1;
              if (a.slave_extra_completion) tx_done = 1;
            end
          end
          default: begin
            b = val[7:0];
            data = val;
            if ((ctrl & CR_MTX) != 0) begin
              if (want_addr) begin
                sel_addr = b[7:1];
                rd_phase = b[0];
                if (!a.slave_present) begin
                  sel = 0;
                  stat |= SR_RXAK;
                  r.unknown_slave = 1'b1;
                end else begin
                  sel = 1;
                  r.slave_start = 1'b1;
                  r.slave_start_read = rd_phase;
                end
                if (rd_phase) begin
                  dummy_rd = 1;
                  rx_shift = '0;
                end
                want_addr = 0;
              end else if (sel && !rd_phase) begin
                r.slave_write_strobe = 1'b1;
                r.slave_write_byte = b;
              end
            end
            stat &= ~SR_ICF;
            tx_done = 1;
            if (!r.unknown_slave) stat &= ~SR_RXAK;
          end
        endcase
      end

      if (sel || r.slave_start || r.slave_write_strobe || r.slave_read_strobe ||
          r.unknown_slave)
        r.slave_address = sel_addr;
      return r;
    endfunction

    function void note_access(req_t a);
      expected_results.push_back(predict_access(a));
    endfunction

    function string show(rsp_t r);
      return $sformatf("rd=%h err=%b unk=%b st=%b st_rd=%b addr=%h ws=%b wb=%h rs=%b cq=%b",
                       r.read_data, r.access_error, r.unknown_slave, r.slave_start,
                       r.slave_start_read, r.slave_address, r.slave_write_strobe,
                       r.slave_write_byte, r.slave_read_strobe, r.completion_query);
    endfunction

    function void check_result(rsp_t got);
      rsp_t  want;
      string bad;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing predicted: %s", show(got));
        return;
      end
      want = expected_results.pop_front();
      checked++;
      n_starts  += want.slave_start;
      n_unknown += want.unknown_slave;
      n_wstb    += want.slave_write_strobe;
      n_rstb    += want.slave_read_strobe;
      n_cq      += want.completion_query;
      n_err     += want.access_error;
      bad = "";
      if (got.read_data !== want.read_data) bad = {bad, " read_data"};
      if (got.access_error !== want.access_error) bad = {bad, " access_error"};
      if (got.unknown_slave !== want.unknown_slave) bad = {bad, " unknown_slave"};
      if (got.slave_start !== want.slave_start) bad = {bad, " slave_start"};
      if (got.slave_start_read !== want.slave_start_read) bad = {bad, " slave_start_read"};
      if (got.slave_address !== want.slave_address) bad = {bad, " slave_address"};
      if (got.slave_write_strobe !== want.slave_write_strobe) bad = {bad, " slave_write_strobe"};
      if (got.slave_write_byte !== want.slave_write_byte) bad = {bad, " slave_write_byte"};
      if (got.slave_read_strobe !== want.slave_read_strobe) bad = {bad, " slave_read_strobe"};
      if (got.completion_query !== want.completion_query) bad = {bad, " completion_query"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d wrong in%s", checked, bad);
          $display("  exp %s", show(want));
          $display("  got %s", show(got));
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;

  logic [31:0] cycle_count = '0;
  int          burst_left = 0;
  int          n_sent = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  i2c_reg_scoreboard sb = new();

  i2c_master_register_block_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count cycles and bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver back-pressure: switch at random among free-running, light, heavy
  // and periodic stall patterns.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(40, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= cycle_count[4];
    endcase
  end

  // Check every result beat the receiver takes.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  // Drive one beat, hold it until accepted, then note it. Between bursts
  // drop valid for a random gap.
  task automatic issue(req_t item);
    int gap;
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_access(item);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic req_t make_access(bit wr, logic [13:0] off, bit half, logic [15:0] wd);
    req_t r;
    r.cmd = wr ? CMD_WRITE : CMD_READ;
    r.addr_offset = off;
    r.halfword_access = half;
    r.write_data = wd;
    r.slave_present = ($urandom_range(0, 7) != 0);
    r.slave_rx_byte = 8'($urandom);
    r.slave_extra_completion = 1'($urandom);
    return r;
  endfunction

  // Random access: wild offsets, offsets near the window, and register
  // offsets with a random lane bit.
  function automatic req_t make_noise();
    logic [13:0] off;
    case ($urandom_range(0, 3))
      0:       off = 14'($urandom);
      1:       off = 14'($urandom_range(0, 31));
      default: off = 14'($urandom_range(0, 4) * 4 + $urandom_range(0, 1));
    endcase
    return make_access(1'($urandom), off, 1'($urandom), 16'($urandom));
  endfunction

  task automatic poke(bit wr, logic [13:0] off, bit half, logic [15:0] wd,
                      bit present = 1'b1, bit extra = 1'b0, logic [7:0] rx = 8'h00);
    req_t r;
    r = make_access(wr, off, half, wd);
    r.slave_present = present;
    r.slave_extra_completion = extra;
    r.slave_rx_byte = rx;
    issue(r);
  endtask

  // Register access inside a transfer: mostly halfword, sometimes a lane-0
  // byte, now and then preceded by a stray access that may break the flow.
  task automatic bus_access(bit wr, logic [13:0] off, logic [15:0] wd);
    if ($urandom_range(0, 11) == 0) issue(make_noise());
    issue(make_access(wr, off, ($urandom_range(0, 3) != 0), wd));
  endtask

  // One master transfer: START, address byte, data phase in either
  // direction, optional repeated STARTs, then STOP.
  task automatic run_transfer();
    int       nbytes;
    int       reps;
    bit       rd;
    bit [6:0] target;
    bus_access(CMD_WRITE, OFF_CONTROL, CR_MSTA | CR_MTX);
    reps = $urandom_range(0, 2);
    for (int k = 0; k <= reps; k++) begin
      rd = 1'($urandom);
      target = 7'($urandom);
      bus_access(CMD_WRITE, OFF_DATA, {8'($urandom), target, rd});
      nbytes = $urandom_range(1, 4);
      if (!rd) begin
        for (int i = 0; i < nbytes; i++) begin
          bus_access(CMD_READ, OFF_STATUS, 16'h0000);
          bus_access(CMD_WRITE, OFF_STATUS, 16'($urandom) & ~SR_IIF);
          bus_access(CMD_WRITE, OFF_DATA, 16'($urandom));
        end
      end else begin
        // drop MTX, then throw away the dummy byte
        bus_access(CMD_WRITE, OFF_CONTROL, CR_MSTA);
        bus_access(CMD_READ, OFF_DATA, 16'h0000);
        for (int i = 0; i < nbytes; i++) begin
          bus_access(CMD_READ, OFF_STATUS, 16'h0000);
          bus_access(CMD_WRITE, OFF_STATUS, 16'($urandom) & ~SR_IIF);
          if (i == nbytes - 1 && k == reps) bus_access(CMD_WRITE, OFF_CONTROL, 16'h0000);
          bus_access(CMD_READ, OFF_DATA, 16'h0000);
        end
      end
      if (k < reps) begin
        bus_access(CMD_WRITE, OFF_CONTROL, CR_MSTA | CR_MTX);
        bus_access(CMD_WRITE, OFF_CONTROL, CR_MSTA | CR_MTX | CR_RSTA);
      end
    end
    if (!rd) bus_access(CMD_WRITE, OFF_CONTROL, 16'h0000);
    bus_access(CMD_READ, OFF_STATUS, 16'h0000);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, byte lanes, bad offsets, unknown slave,
    // write transfer with completion query, read transfer with dummy read
    // and STOP held back to the final byte.
    poke(CMD_WRITE, OFF_OWN_ADDR, 1, 16'hFFFF);
    poke(CMD_READ,  OFF_OWN_ADDR, 1, 16'h0000);
    poke(CMD_WRITE, OFF_CLK_DIV + 14'd1, 0, 16'h00FF);
    poke(CMD_READ,  OFF_CLK_DIV + 14'd1, 0, 16'h0000);
    poke(CMD_READ,  14'h0001, 1, 16'h0000);
    poke(CMD_WRITE, 14'h0014, 1, 16'hFFFF);
    poke(CMD_READ,  14'h3FFF, 0, 16'h0000);
    poke(CMD_WRITE, OFF_CONTROL, 1, CR_MSTA | CR_MTX);
    poke(CMD_WRITE, OFF_DATA, 1, 16'h00A0, 1'b0);
    poke(CMD_WRITE, OFF_DATA, 1, 16'h0055);
    poke(CMD_READ,  OFF_STATUS, 0, 16'h0000);
    poke(CMD_WRITE, OFF_CONTROL, 1, CR_MSTA | CR_MTX | CR_RSTA);
    poke(CMD_WRITE, OFF_DATA, 1, 16'hFF42);
    poke(CMD_WRITE, OFF_DATA, 1, 16'h00FF);
    poke(CMD_WRITE, OFF_DATA + 14'd1, 0, 16'h00AB);
    poke(CMD_WRITE, OFF_STATUS, 1, 16'h0000, 1'b1, 1'b1);
    poke(CMD_READ,  OFF_STATUS, 1, 16'h0000);
    poke(CMD_WRITE, OFF_CONTROL, 1, CR_MSTA | CR_MTX);
    poke(CMD_WRITE, OFF_CONTROL, 1, CR_MSTA | CR_MTX | CR_RSTA);
    poke(CMD_WRITE, OFF_DATA, 1, 16'h0043);
    poke(CMD_WRITE, OFF_CONTROL, 1, CR_MSTA | CR_RSTA);
    poke(CMD_READ,  OFF_STATUS, 1, 16'h0000);
    poke(CMD_READ,  OFF_DATA, 0, 16'h0000, 1'b1, 1'b0, 8'h5A);
    poke(CMD_WRITE, OFF_STATUS, 1, 16'hFFFD);
    poke(CMD_READ,  OFF_STATUS, 1, 16'h0000);
    poke(CMD_WRITE, OFF_CONTROL, 1, 16'h0000);
    poke(CMD_READ,  OFF_DATA, 1, 16'h0000, 1'b1, 1'b0, 8'hFF);
    poke(CMD_READ,  OFF_DATA + 14'd1, 0, 16'h0000);

    // Random: mostly well-formed transfers, the rest stray accesses.
    while (n_sent < RANDOM_BEATS + 28) begin
      if ($urandom_range(0, 3) != 0) run_transfer();
      else repeat ($urandom_range(1, 6)) issue(make_noise());
    end
    req_valid <= 1'b0;

    // Drain, then give the output stage spare cycles to settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d accesses, checked %0d results: %0d starts, %0d unknown slaves,",
             n_sent, sb.checked, sb.n_starts, sb.n_unknown);
    $display("%0d bytes sent, %0d bytes received, %0d completion queries, %0d bad offsets",
             sb.n_wstb, sb.n_rstb, sb.n_cq, sb.n_err);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
